/* src/daf_pkg.sv */
package daf_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int ACK_W       = 32;

  typedef enum logic [1:0] {
    KIND_PUSH   = 2'd0,
    KIND_POP    = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_QUERY  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_MISS  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic latch_in;
    logic execute;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_result;
    logic out_busy;
  } sts_t;

endpackage

/* src/daf_ctrl.sv */
module daf_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  daf_pkg::sts_t sts,
  output daf_pkg::cmd_t cmd
);
  import daf_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next   = state;
    cmd.latch_in = 1'b0;
    cmd.execute  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_next   = S_EXEC;
        end
      end
      S_EXEC: begin
        // hold while the previous result is still waiting
        if (!(sts.need_result && sts.out_busy)) begin
          cmd.execute = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_no_exec_and_accept: assert property (@(posedge clk) disable iff (rst)
    !(cmd.execute && cmd.latch_in))
    else $error("execute and accept in the same cycle");

endmodule

/* src/daf_datapath.sv */
module daf_datapath (
  input  logic                      clk,
  input  logic                      rst,
  input  daf_pkg::cmd_t             cmd,
  output daf_pkg::sts_t             sts,
  input  logic [1:0]                kind,
  input  logic [daf_pkg::ACK_W-1:0] ack_value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      ok,
  output logic [1:0]                status,
  output logic [daf_pkg::ACK_W-1:0] popped_value
);
  import daf_pkg::*;

  logic [ACK_W-1:0]       entries [QUEUE_DEPTH];
  logic [CNT_W-1:0]       count;
  kind_t                  op;
  logic [ACK_W-1:0]       val;

  logic [QUEUE_DEPTH-1:0] match;
  logic [QUEUE_DEPTH-1:0] at_or_after;
  logic [QUEUE_DEPTH-1:0] shift_en;
  logic                   hit, full, empty;
  logic                   do_push, do_pop, do_remove;
  logic                   res_ok;
  status_t                res_status;
  logic [ACK_W-1:0]       res_value;

  assign full  = (count == CNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      match[i] = (CNT_W'(i) < count) && (entries[i] == val);
    end
  end

  assign hit = |match;

  // entry i shifts down when the removed word sits at or below it
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      at_or_after[i] = |(match & ({QUEUE_DEPTH{1'b1}} >> (QUEUE_DEPTH - 1 - i)));
    end
  end

  assign do_push   = (op == KIND_PUSH) && !hit && !full;
  assign do_pop    = (op == KIND_POP) && !empty;
  assign do_remove = (op == KIND_REMOVE) && hit;
  assign shift_en  = do_pop ? {QUEUE_DEPTH{1'b1}} :
                     (do_remove ? at_or_after : '0);

  always_comb begin
    res_ok     = 1'b0;
    res_status = ST_DONE;
    res_value  = '0;
    unique case (op)
      KIND_PUSH: begin
        if (hit) begin
          res_status = ST_MISS;
        end else if (full) begin
          res_status = ST_FULL;
        end else begin
          res_ok = 1'b1;
        end
      end
      KIND_POP: begin
        if (empty) begin
          res_status = ST_EMPTY;
        end else begin
          res_ok    = 1'b1;
          res_value = entries[0];
        end
      end
      KIND_REMOVE: begin
        res_status = ST_DONE;
      end
      KIND_QUERY: begin
        res_ok     = hit;
        res_status = hit ? ST_DONE : ST_MISS;
      end
      default: res_status = ST_DONE;
    endcase
  end

  assign sts.need_result = (op != KIND_REMOVE);
  assign sts.out_busy    = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op  <= kind_t'(kind);
      val <= ack_value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        if (shift_en[i]) begin
          if (i < QUEUE_DEPTH - 1) begin
            entries[i] <= entries[i + 1];
          end
        end else if (do_push && (count == CNT_W'(i))) begin
          entries[i] <= val;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.execute) begin
      if (do_push) begin
        count <= count + CNT_W'(1);
      end else if (do_pop || do_remove) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.execute && sts.need_result) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute && sts.need_result) begin
      ok           <= res_ok;
      status       <= res_status;
      popped_value <= res_value;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("fill count beyond queue depth");

  a_no_duplicates: assert property (@(posedge clk) disable iff (rst)
    $onehot0(match))
    else $error("value held twice in queue");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.execute && sts.need_result |-> !sts.out_busy)
    else $error("result written over a pending word");

  a_value_only_on_pop: assert property (@(posedge clk) disable iff (rst)
    out_valid && !ok |-> popped_value == '0)
    else $error("popped value set on a failed result");

endmodule

/* src/dedup_ack_fifo_top.sv */
// dedup_ack_fifo_top: queue of pending acknowledgement numbers, each held once.
// input channel (in_valid/in_ready) carries kind and ack_value:
//   push appends unless the value is queued (status 1) or the queue is full
//   (status 3); pop returns the oldest value or reports empty (status 2);
//   remove deletes a value anywhere and closes the gap, with no result word;
//   query reports whether the value is queued.
// output channel (out_valid/out_ready) carries ok, status and popped_value.
// timing: a word is taken in S_IDLE and executed in S_EXEC, where all
//   queue slots are compared in parallel and shifted in one step; the result
//   is registered at execute. in_ready is high only in S_IDLE, so a new word
//   is taken only after the last one has executed.
// the result sits in an output register; the next item is accepted while it
//   waits, but that item, unless a remove, holds in execute until the result is taken.
// reset empties the queue and drops any pending result; slot contents
//   are not cleared, only the fill count is.
module dedup_ack_fifo_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                kind,
  input  logic [daf_pkg::ACK_W-1:0] ack_value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      ok,
  output logic [1:0]                status,
  output logic [daf_pkg::ACK_W-1:0] popped_value
);
  import daf_pkg::*;

  cmd_t cmd;
  sts_t sts;

  daf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  daf_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .kind         (kind),
    .ack_value    (ack_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .ok           (ok),
    .status       (status),
    .popped_value (popped_value)
  );

endmodule

/* bench/dedup_ack_fifo_top_tb.sv */
`timescale 1ns / 1ps

module dedup_ack_fifo_top_tb;
  import daf_pkg::*;

  typedef struct packed {
    logic             ok;
    status_t          status;
    logic [ACK_W-1:0] value;
  } ack_result_t;

  typedef struct packed {
    kind_t            k;
    logic [ACK_W-1:0] v;
    logic             typed;
    ack_result_t      want;
  } op_row_t;

  localparam ack_result_t NO_RESULT = '0;
  localparam int RANDOM_OPS = 1675;
  localparam int QUIET_OPS  = 200;

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_ready;
  kind_t            op_kind;
  logic [ACK_W-1:0] op_value;
  logic             out_valid;
  logic             out_ready;
  logic             ok;
  logic [1:0]       status;
  logic [ACK_W-1:0] popped_value;

  // typed expectation travels with the word on the input side
  logic             cur_typed;
  ack_result_t      cur_want;

  logic [ACK_W-1:0] queued_acks[$];
  ack_result_t      pending_results[$];
  op_row_t          directed_ops[$];
  logic [ACK_W-1:0] ack_pool[20];
  int               err_count;
  int               idle_odds;
  bit               quiet;

  dedup_ack_fifo_top DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (op_kind),
    .ack_value    (op_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .ok           (ok),
    .status       (status),
    .popped_value (popped_value)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // applies one operation to the local copy of the queue
  function automatic logic apply_ack_op(input kind_t k, input logic [ACK_W-1:0] v,
                                        output ack_result_t r);
    int pos = -1;
    foreach (queued_acks[i]) begin
      if (pos < 0 && queued_acks[i] == v) pos = i;
    end
    r = NO_RESULT;
    case (k)
      KIND_PUSH: begin
        if (pos >= 0) r.status = ST_MISS;
        else if (queued_acks.size() >= QUEUE_DEPTH) r.status = ST_FULL;
        else begin
          queued_acks.insert(queued_acks.size(), v);
          r.ok = 1'b1;
        end
        return 1'b1;
      end
      KIND_POP: begin
        if (queued_acks.size() == 0) r.status = ST_EMPTY;
        else begin
          r.value = queued_acks[0];
          queued_acks.delete(0);
          r.ok = 1'b1;
        end
        return 1'b1;
      end
      KIND_REMOVE: begin
        if (pos >= 0) queued_acks.delete(pos);
        return 1'b0;
      end
      default: begin
        r.ok = (pos >= 0);
        r.status = (pos >= 0) ? ST_DONE : ST_MISS;
        return 1'b1;
      end
    endcase
  endfunction

  always @(posedge clk) begin
    ack_result_t r;
    ack_result_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        if (apply_ack_op(op_kind, op_value, r))
          pending_results.insert(pending_results.size(), cur_typed ? cur_want : r);
      end
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected word: expected none, got ok %0d status %0d value %h",
                   $time, ok, status, popped_value);
          err_count++;
        end else begin
          want = pending_results[0];
          pending_results.delete(0);
          if (ok !== want.ok) begin
            $display("%0t: ok mismatch: expected %0d, got %0d", $time, want.ok, ok);
            err_count++;
          end
          if (status !== want.status) begin
            $display("%0t: status mismatch: expected %0d, got %0d", $time, want.status, status);
            err_count++;
          end
          if (popped_value !== want.value) begin
            $display("%0t: popped_value mismatch: expected %h, got %h",
                     $time, want.value, popped_value);
            err_count++;
          end
        end
      end
    end
  end

  // receiver stalls in bursts
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (!quiet && idle_odds != 0 && $urandom_range(0, 99) < idle_odds) begin
        out_ready <= 1'b0;
        stall_left = $urandom_range(1, 18) - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // entered and left just after a falling edge
  task automatic send_word(input kind_t k, input logic [ACK_W-1:0] v,
                           input logic typed, input ack_result_t want);
    if (!quiet && idle_odds != 0 && $urandom_range(0, 99) < idle_odds) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_valid  <= 1'b1;
    op_kind   <= k;
    op_value  <= v;
    cur_typed <= typed;
    cur_want  <= want;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  function automatic logic [ACK_W-1:0] pick_value(input logic try_queued);
    if (try_queued && queued_acks.size() != 0 && $urandom_range(0, 1))
      return queued_acks[$urandom_range(0, queued_acks.size() - 1)];
    if ($urandom_range(0, 5) == 0)
      return $urandom;
    return ack_pool[$urandom_range(0, 19)];
  endfunction

  initial begin
    kind_t            k;
    logic [ACK_W-1:0] v;
    int               push_pct;
    int               pick;
    rst       = 1'b1;
    in_valid  = 1'b0;
    op_kind   = KIND_PUSH;
    op_value  = '0;
    out_ready = 1'b0;
    cur_typed = 1'b0;
    cur_want  = NO_RESULT;
    err_count = 0;
    idle_odds = 10;
    quiet     = 1'b0;
    ack_pool[0] = 32'h0000_0000;
    ack_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < 20; i++) ack_pool[i] = $urandom;

    directed_ops = '{
      '{KIND_POP,    32'h0000_0000, 1'b1, '{1'b0, ST_EMPTY, 32'h0}},
      '{KIND_REMOVE, 32'h0000_0005, 1'b0, NO_RESULT},
      '{KIND_PUSH,   32'h0000_0000, 1'b1, '{1'b1, ST_DONE, 32'h0}},
      '{KIND_PUSH,   32'h0000_0000, 1'b1, '{1'b0, ST_MISS, 32'h0}},
      '{KIND_PUSH,   32'hFFFF_FFFF, 1'b1, '{1'b1, ST_DONE, 32'h0}},
      '{KIND_QUERY,  32'hFFFF_FFFF, 1'b1, '{1'b1, ST_DONE, 32'h0}},
      '{KIND_PUSH,   32'h5555_5555, 1'b0, NO_RESULT},
      '{KIND_PUSH,   32'hAAAA_AAAA, 1'b0, NO_RESULT},
      '{KIND_PUSH,   32'h0000_0001, 1'b0, NO_RESULT},
      '{KIND_PUSH,   32'h8000_0000, 1'b0, NO_RESULT},
      '{KIND_PUSH,   32'h7FFF_FFFF, 1'b0, NO_RESULT},
      '{KIND_PUSH,   32'h0F0F_0F0F, 1'b0, NO_RESULT},
      '{KIND_PUSH,   32'hF0F0_F0F0, 1'b0, NO_RESULT},
      '{KIND_PUSH,   32'h3333_3333, 1'b0, NO_RESULT},
      '{KIND_PUSH,   32'hCCCC_CCCC, 1'b0, NO_RESULT},
      '{KIND_PUSH,   32'h0000_FFFF, 1'b0, NO_RESULT},
      '{KIND_PUSH,   32'hFFFF_0000, 1'b0, NO_RESULT},
      '{KIND_PUSH,   32'h1234_5678, 1'b0, NO_RESULT},
      '{KIND_PUSH,   32'h8765_4321, 1'b0, NO_RESULT},
      '{KIND_PUSH,   32'hFFFF_FFFE, 1'b0, NO_RESULT},
      // queue is full now; the duplicate test wins over the full test
      '{KIND_PUSH,   32'hDEAD_BEEF, 1'b1, '{1'b0, ST_FULL, 32'h0}},
      '{KIND_PUSH,   32'h5555_5555, 1'b1, '{1'b0, ST_MISS, 32'h0}},
      // remove from the middle, then the gap must be closed in order
      '{KIND_REMOVE, 32'h8000_0000, 1'b0, NO_RESULT},
      '{KIND_QUERY,  32'h8000_0000, 1'b1, '{1'b0, ST_MISS, 32'h0}},
      '{KIND_POP,    32'h0000_0000, 1'b1, '{1'b1, ST_DONE, 32'h0000_0000}},
      '{KIND_POP,    32'hFFFF_FFFF, 1'b1, '{1'b1, ST_DONE, 32'hFFFF_FFFF}}
    };

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_ops[i])
      send_word(directed_ops[i].k, directed_ops[i].v, directed_ops[i].typed,
                directed_ops[i].want);

    push_pct = 50;
    for (int n = 0; n < RANDOM_OPS; n++) begin
      // fill-heavy and drain-heavy stretches so full and empty both come up
      if (n % 60 == 0) begin
        case ($urandom_range(0, 2))
          0: push_pct = 75;
          1: push_pct = 45;
          default: push_pct = 15;
        endcase
        case ($urandom_range(0, 2))
          0: idle_odds = 0;
          1: idle_odds = 8;
          default: idle_odds = 30;
        endcase
      end
      if (n == RANDOM_OPS - QUIET_OPS) quiet = 1'b1;
      if (n == 800) begin
        in_valid <= 1'b0;
        do @(negedge clk); while (pending_results.size() != 0);
      end
      if ($urandom_range(0, 99) < push_pct) begin
        k = KIND_PUSH;
        v = pick_value(1'b0);
      end else begin
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
          k = KIND_POP;
          v = $urandom;
        end else begin
          k = (pick < 7) ? KIND_REMOVE : KIND_QUERY;
          v = pick_value(1'b1);
        end
      end
      send_word(k, v, 1'b0, NO_RESULT);
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_count == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
